### rtl/psc_pkg.sv
package psc_pkg;

	// register file
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_POT_MIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POT_MAX    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POT_MID    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_SPEED  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CHANGE_THR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTVL  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MOVE_THR   = 3'd7;

	localparam logic [11:0] RST_POT_MIN    = 12'd0;
	localparam logic [11:0] RST_POT_MAX    = 12'd4095;
	localparam logic [11:0] RST_POT_MID    = 12'd2048;
	localparam logic [10:0] RST_DEADBAND   = 11'd307;
	localparam logic [6:0]  RST_TOP_SPEED  = 7'd100;
	localparam logic [7:0]  RST_CHANGE_THR = 8'd3;
	localparam logic [15:0] RST_MIN_INTVL  = 16'd200;
	localparam logic [11:0] RST_MOVE_THR   = 12'd50;

	// command direction codes
	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_BWD  = 2'd2;

	typedef struct packed {
		logic [11:0] pot_min;
		logic [11:0] pot_max;
		logic [11:0] pot_mid;
		logic [10:0] deadband;
		logic [6:0]  top_speed;
		logic [7:0]  change_threshold;
		logic [15:0] min_interval_ms;
		logic [11:0] move_threshold;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;  // take the input word
		logic prep;     // select map side, load divider
		logic step;     // one restoring divide step
		logic commit;   // finish speed, decide, update state, load output
	} cmd_t;

endpackage

### rtl/psc_ctrl.sv
module psc_ctrl #(
	parameter int DIV_STEPS = 20
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	output psc_pkg::cmd_t cmd
);

	localparam int CW = $clog2(DIV_STEPS);
	localparam logic [CW-1:0] CNT_LAST = CW'(DIV_STEPS - 1);

	typedef enum logic [1:0] {S_IDLE, S_PREP, S_DIV, S_FIN} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.capture = in_valid && (state_q == S_IDLE);
		cmd.prep    = (state_q == S_PREP);
		cmd.step    = (state_q == S_DIV);
		cmd.commit  = (state_q == S_FIN) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one taken in the same cycle
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_PREP;
				end
				S_PREP: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/psc_dp.sv
module psc_dp #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  psc_pkg::cmd_t          cmd,
	input  psc_pkg::cfg_t          cfg,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	input  logic [31:0]            in_now,
	input  logic                   in_stop,
	output logic                   out_send,
	output logic [1:0]             out_dir,
	output logic [6:0]             out_mag,
	output logic                   out_moved
);

	localparam int MW = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
	localparam int XW = MW + 2;        // signed span arithmetic
	localparam int NB = XW - 1 + 7;    // numerator / quotient bits

	// captured word
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [31:0]            now_q;
	logic                   stop_q;

	// divider
	logic          fwd_q, act_q, qneg_q, den_zero_q;
	logic [XW-2:0] den_q;
	logic [XW-2:0] rem_q;
	logic [NB-1:0] quo_q;

	// persistent state
	logic signed [7:0]      last_speed_q;
	logic [31:0]            last_time_q;
	logic [SAMPLE_BITS-1:0] baseline_q;
	logic                   loaded_q;

	// output word
	logic       send_q, moved_q;
	logic [1:0] dir_q;
	logic [6:0] mag_q;

	// ---- side select and numerator
	logic signed [XW-1:0] raw_s, pmin_s, pmax_s, lo_s, hi_s, dx_s, dx_neg, den_s, den_neg;
	logic                 fwd, bwd;
	logic [XW-2:0]        dx_mag, den_mag;
	logic [NB-1:0]        num_mag;

	always_comb begin
		raw_s   = $signed({{(XW-SAMPLE_BITS){1'b0}}, sample_q});
		pmin_s  = $signed({{(XW-12){1'b0}}, cfg.pot_min});
		pmax_s  = $signed({{(XW-12){1'b0}}, cfg.pot_max});
		lo_s    = $signed({{(XW-12){1'b0}}, cfg.pot_mid}) - $signed({{(XW-11){1'b0}}, cfg.deadband});
		hi_s    = $signed({{(XW-12){1'b0}}, cfg.pot_mid}) + $signed({{(XW-11){1'b0}}, cfg.deadband});
		fwd     = raw_s < lo_s;
		bwd     = raw_s > hi_s;
		dx_s    = fwd ? (raw_s - pmin_s) : (raw_s - hi_s);
		den_s   = fwd ? (lo_s - pmin_s) : (pmax_s - hi_s);
		dx_neg  = -dx_s;
		den_neg = -den_s;
		dx_mag  = dx_s[XW-1] ? dx_neg[XW-2:0] : dx_s[XW-2:0];
		den_mag = den_s[XW-1] ? den_neg[XW-2:0] : den_s[XW-2:0];
		num_mag = NB'(dx_mag) * NB'(cfg.top_speed);
	end

	// ---- restoring divide step
	logic [XW-1:0] sh, sh_sub;
	logic          ge;

	always_comb begin
		sh     = {rem_q, quo_q[NB-1]};
		ge     = sh >= {1'b0, den_q};
		sh_sub = sh - {1'b0, den_q};
	end

	// ---- finish: speed, decision, movement
	logic signed [NB:0]   qpos, qv;
	logic signed [NB+1:0] sw, smax_w;
	logic signed [7:0]    speed, last_eff, speed_neg;
	logic signed [8:0]    dsp, dsp_neg;
	logic [8:0]           dabs;
	logic [31:0]          elapsed;
	logic                 trans, send;
	logic [1:0]           dir;
	logic [6:0]           mag;
	logic [MW-1:0]        s_ext, b_ext, dmove;
	logic                 mv;

	always_comb begin
		qpos = $signed({1'b0, quo_q});
		qv   = qneg_q ? -qpos : qpos;
		if (!act_q || den_zero_q)
			qv = '0;
		smax_w = $signed({{(NB-5){1'b0}}, cfg.top_speed});
		sw     = $signed({qv[NB], qv}) + (fwd_q ? smax_w : '0);
		if (sw > smax_w)
			speed = $signed({1'b0, cfg.top_speed});
		else if (sw < -smax_w)
			speed = -$signed({1'b0, cfg.top_speed});
		else
			speed = sw[7:0];

		last_eff = stop_q ? 8'sd0 : last_speed_q;
		dsp      = $signed({speed[7], speed}) - $signed({last_eff[7], last_eff});
		dsp_neg  = -dsp;
		dabs     = dsp[8] ? dsp_neg : dsp;
		trans    = (speed == 8'sd0) != (last_eff == 8'sd0);
		elapsed  = now_q - last_time_q;
		send     = trans || ((dabs >= {1'b0, cfg.change_threshold})
			&& (elapsed >= {16'd0, cfg.min_interval_ms}));

		speed_neg = -speed;
		dir = psc_pkg::DIR_STOP;
		mag = '0;
		if (send && speed > 8'sd0) begin
			dir = psc_pkg::DIR_FWD;
			mag = speed[6:0];
		end else if (send && speed < 8'sd0) begin
			dir = psc_pkg::DIR_BWD;
			mag = speed_neg[6:0];
		end

		s_ext = MW'(sample_q);
		b_ext = MW'(baseline_q);
		dmove = (s_ext > b_ext) ? (s_ext - b_ext) : (b_ext - s_ext);
		mv    = loaded_q && (dmove > MW'(cfg.move_threshold));
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= in_sample;
			now_q    <= in_now;
			stop_q   <= in_stop;
		end
		if (cmd.prep) begin
			fwd_q      <= fwd;
			act_q      <= fwd || bwd;
			qneg_q     <= !dx_s[XW-1] ^ den_s[XW-1];
			den_zero_q <= (den_mag == '0);
			den_q      <= den_mag;
			rem_q      <= '0;
			quo_q      <= num_mag;
		end
		if (cmd.step) begin
			rem_q <= ge ? sh_sub[XW-2:0] : sh[XW-2:0];
			quo_q <= {quo_q[NB-2:0], ge};
		end
		if (cmd.commit) begin
			send_q  <= send;
			dir_q   <= dir;
			mag_q   <= mag;
			moved_q <= mv;
		end
	end

	// state carried from word to word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_speed_q <= '0;
			last_time_q  <= '0;
			baseline_q   <= '0;
			loaded_q     <= 1'b0;
		end else if (cmd.commit) begin
			if (send) begin
				last_speed_q <= speed;
				last_time_q  <= now_q;
			end else if (stop_q) begin
				last_speed_q <= '0;
			end
			if (!loaded_q || mv)
				baseline_q <= sample_q;
			loaded_q <= 1'b1;
		end
	end

	assign out_send  = send_q;
	assign out_dir   = dir_q;
	assign out_mag   = mag_q;
	assign out_moved = moved_q;

endmodule

### rtl/pot_speed_command_limiter_top.sv
// channel | signals                                   | accepted when
// --------+-------------------------------------------+----------------------
// cfg     | cfg_we, cfg_index[2:0], cfg_data[15:0]     | cfg_we high
// in      | in_valid/in_ready, pot_sample, now_ms,     | in_valid & in_ready
//         | stop_event                                 |
// out     | out_valid/out_ready, send_cmd, direction,  | out_valid & out_ready
//         | magnitude, moved                           |
//
// A word is taken while idle; its result comes after a setup step, the restoring
// divider at one quotient bit per cycle (max(SAMPLE_BITS,12)+8 steps) and a
// finish step that loads the output register.
// The divider is the limit: the next word is taken only once the block is back in
// idle after the finish. A new word may be accepted while a result waits; the
// finish stage holds until the output register frees.
// Reset is asynchronous, active low; config writes are expected only while idle.
module pot_speed_command_limiter_top #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_we,
	input  logic [psc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [psc_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input words
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [SAMPLE_BITS-1:0]          pot_sample,
	input  logic [31:0]                     now_ms,
	input  logic                            stop_event,
	// result words
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            send_cmd,
	output logic [1:0]                      direction,
	output logic [6:0]                      magnitude,
	output logic                            moved
);

	localparam int MW        = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
	localparam int DIV_STEPS = MW + 8;

	psc_pkg::cfg_t cfg_q;
	psc_pkg::cmd_t cmd;

	// register file, write-only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pot_min          <= psc_pkg::RST_POT_MIN;
			cfg_q.pot_max          <= psc_pkg::RST_POT_MAX;
			cfg_q.pot_mid          <= psc_pkg::RST_POT_MID;
			cfg_q.deadband         <= psc_pkg::RST_DEADBAND;
			cfg_q.top_speed        <= psc_pkg::RST_TOP_SPEED;
			cfg_q.change_threshold <= psc_pkg::RST_CHANGE_THR;
			cfg_q.min_interval_ms  <= psc_pkg::RST_MIN_INTVL;
			cfg_q.move_threshold   <= psc_pkg::RST_MOVE_THR;
		end else if (cfg_we) begin
			case (cfg_index)
				psc_pkg::REG_POT_MIN:    cfg_q.pot_min          <= cfg_data[11:0];
				psc_pkg::REG_POT_MAX:    cfg_q.pot_max          <= cfg_data[11:0];
				psc_pkg::REG_POT_MID:    cfg_q.pot_mid          <= cfg_data[11:0];
				psc_pkg::REG_DEADBAND:   cfg_q.deadband         <= cfg_data[10:0];
				psc_pkg::REG_TOP_SPEED:  cfg_q.top_speed        <= cfg_data[6:0];
				psc_pkg::REG_CHANGE_THR: cfg_q.change_threshold <= cfg_data[7:0];
				psc_pkg::REG_MIN_INTVL:  cfg_q.min_interval_ms  <= cfg_data[15:0];
				psc_pkg::REG_MOVE_THR:   cfg_q.move_threshold   <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	psc_ctrl #(
		.DIV_STEPS(DIV_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	psc_dp #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.in_sample (pot_sample),
		.in_now    (now_ms),
		.in_stop   (stop_event),
		.out_send  (send_cmd),
		.out_dir   (direction),
		.out_mag   (magnitude),
		.out_moved (moved)
	);

endmodule

### rtl/psc_chk.sv
module psc_chk #(
	parameter int SAMPLE_BITS = 12
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_we,
	input logic [psc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [psc_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [SAMPLE_BITS-1:0]         pot_sample,
	input logic [31:0]                    now_ms,
	input logic                           stop_event,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           send_cmd,
	input logic [1:0]                     direction,
	input logic [6:0]                     magnitude,
	input logic                           moved
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(send_cmd) && $stable(direction)
			&& $stable(magnitude) && $stable(moved))
		else $error("stalled result word changed");

	// no command means a blank command field
	a_no_cmd_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !send_cmd |-> direction == psc_pkg::DIR_STOP && magnitude == 7'd0)
		else $error("command fields set without a command");

	// a stop command carries zero, a moving one carries a speed
	a_dir_mag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && send_cmd |-> (direction == psc_pkg::DIR_STOP) == (magnitude == 7'd0))
		else $error("direction and magnitude disagree");

	// one word at a time: accepting puts the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after accept");

endmodule

bind pot_speed_command_limiter_top psc_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_psc_chk (.*);
